[hw/rtl/trsc_pkg.sv]
`default_nettype none

package trsc_pkg;

  // Data store geometry.
  localparam int unsigned ADDR_BITS = 16;
  localparam int unsigned MEM_WORDS = 1 << ADDR_BITS;

  // Word modes on the input channel.
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_EXEC  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Opcodes, held in bits 7:0 of an instruction.
  localparam logic [7:0] OPC_LDC    = 8'd0;
  localparam logic [7:0] OPC_ADC    = 8'd1;
  localparam logic [7:0] OPC_LDL    = 8'd2;
  localparam logic [7:0] OPC_STL    = 8'd3;
  localparam logic [7:0] OPC_LDNL   = 8'd4;
  localparam logic [7:0] OPC_STNL   = 8'd5;
  localparam logic [7:0] OPC_ADD    = 8'd6;
  localparam logic [7:0] OPC_SUB    = 8'd7;
  localparam logic [7:0] OPC_SHL    = 8'd8;
  localparam logic [7:0] OPC_SHR    = 8'd9;
  localparam logic [7:0] OPC_ADJ    = 8'd10;
  localparam logic [7:0] OPC_A2SP   = 8'd11;
  localparam logic [7:0] OPC_SP2A   = 8'd12;
  localparam logic [7:0] OPC_CALL   = 8'd13;
  localparam logic [7:0] OPC_RETURN = 8'd14;
  localparam logic [7:0] OPC_BRZ    = 8'd15;
  localparam logic [7:0] OPC_BRLZ   = 8'd16;
  localparam logic [7:0] OPC_BR     = 8'd17;
  localparam logic [7:0] OPC_HALT   = 8'd18;

  // Stop codes.
  localparam logic [2:0] STAT_RUN      = 3'd0;
  localparam logic [2:0] STAT_HALT     = 3'd1;
  localparam logic [2:0] STAT_INVALID  = 3'd2;
  localparam logic [2:0] STAT_STEP_LIM = 3'd3;
  localparam logic [2:0] STAT_STACK_OV = 3'd4;

  // Configuration register indexes and reset values.
  localparam logic CFG_STEP_LIMIT  = 1'b0;
  localparam logic CFG_STACK_LIMIT = 1'b1;

  localparam logic [31:0] STEP_LIMIT_RST  = 32'd100000;
  localparam logic [31:0] STACK_LIMIT_RST = 32'h0080_0000;

endpackage

`default_nettype wire

[hw/rtl/two_register_stack_cpu_step.sv]
`default_nettype none

// Two-register stack machine, one word per handshake on the input channel.
// An input word either writes a data word (mode 0), executes one instruction
// (mode 1) or reads a data word (mode 2); every accepted word yields exactly
// one result word carrying A, B, PC, SP, the stop status, the read data and
// the instruction count as they stand after that word.
// Both channels use valid/ready. When a word is taken, its data store
// address is formed from the word and the current registers and the store is
// read. Once the output slot is free, the read data is used, the registers
// and the store are updated and the result is presented. The block accepts
// no further word until that result is presented, since the single-ported
// store's registered read feeds the update.
// If the receiver stalls, the result stays on the output, and one further
// word is still accepted and waits, fully read, until the result is taken.
// After reset the block clears the data store one word per cycle, all
// 2^ADDR_BITS (65536) words; no word is accepted during that pass, while the
// configuration port may be written at any time.
module two_register_stack_cpu_step
  import trsc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_addr_i,
  input  wire logic [31:0]        cfg_data_i,
  // Input channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic [15:0]        address_i,
  input  wire logic signed [31:0] write_word_i,
  input  wire logic [31:0]        instruction_i,
  // Output channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      acc_a_o,
  output logic signed [31:0]      acc_b_o,
  output logic signed [31:0]      prog_counter_o,
  output logic signed [31:0]      stack_ptr_o,
  output logic [2:0]              status_o,
  output logic signed [31:0]      read_word_o,
  output logic [31:0]             steps_done_o
);

  typedef enum logic [1:0] {
    PH_CLEAR,
    PH_IDLE,
    PH_EXEC
  } phase_e;

  phase_e phase_q, phase_d;

  // Architectural state. The outputs are taken straight from these, since
  // they change only at the edge at which a result is presented.
  logic [31:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [31:0] pc_q, pc_d;
  logic [31:0] sp_q, sp_d;
  logic [31:0] cnt_q, cnt_d;
  logic [2:0]  stop_q, stop_d;
  logic [31:0] rword_q, rword_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] step_lim_q, stack_lim_q;

  logic [ADDR_BITS-1:0] clr_q, clr_d;

  // The word being executed, captured at accept.
  logic [1:0]           mode_q;
  logic [31:0]          wword_q;
  logic [31:0]          instr_q;
  logic [ADDR_BITS-1:0] addr_q;

  // Data store.
  logic [31:0]          mem [MEM_WORDS];
  logic [31:0]          rd_q;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_wa;
  logic [31:0]          mem_wd;

  logic                 accept;
  logic                 commit;
  logic [7:0]           in_opc;
  logic [31:0]          in_v;
  logic [31:0]          in_base;
  logic [31:0]          in_addr_ext;
  logic [ADDR_BITS-1:0] in_addr;

  logic [7:0]  opc;
  logic [31:0] v;
  logic [31:0] a_n, b_n, pc_n, sp_n;
  logic        st_we;
  logic [31:0] st_wd;
  logic [31:0] cnt_inc;

  assign in_ready_o  = (phase_q == PH_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  // A result is presented only once the output slot is free.
  assign commit      = (phase_q == PH_EXEC) && (!out_valid_q || out_ready_i);

  // Address of the store access for an incoming word. Local and non-local
  // loads and stores add the operand to SP or to A; the data modes use the
  // address field.
  assign in_opc      = instruction_i[7:0];
  assign in_v        = {{8{instruction_i[31]}}, instruction_i[31:8]};
  assign in_addr_ext = 32'(address_i);

  always_comb begin
    in_base = in_addr_ext;
    if (mode_i == MODE_EXEC) begin
      if (in_opc == OPC_LDL || in_opc == OPC_STL) begin
        in_base = sp_q + in_v;
      end else if (in_opc == OPC_LDNL || in_opc == OPC_STNL) begin
        in_base = a_q + in_v;
      end
    end
  end

  assign in_addr = in_base[ADDR_BITS-1:0];

  // Instruction decode for the word in execution.
  assign opc     = instr_q[7:0];
  assign v       = {{8{instr_q[31]}}, instr_q[31:8]};
  assign cnt_inc = cnt_q + 32'd1;

  always_comb begin
    a_n   = a_q;
    b_n   = b_q;
    pc_n  = pc_q;
    sp_n  = sp_q;
    st_we = 1'b0;
    st_wd = a_q;
    case (opc)
      OPC_LDC: begin
        b_n = a_q;
        a_n = v;
      end
      OPC_ADC: a_n = a_q + v;
      OPC_LDL: begin
        b_n = a_q;
        a_n = rd_q;
      end
      OPC_STL: begin
        st_we = 1'b1;
        st_wd = a_q;
        a_n   = b_q;
      end
      OPC_LDNL: a_n = rd_q;
      OPC_STNL: begin
        st_we = 1'b1;
        st_wd = b_q;
      end
      OPC_ADD: a_n = b_q + a_q;
      OPC_SUB: a_n = b_q - a_q;
      OPC_SHL: begin
        // Shift amounts beyond 31 clear the word.
        if (a_q > 32'd31) begin
          a_n = '0;
        end else begin
          a_n = b_q << a_q[4:0];
        end
      end
      OPC_SHR: begin
        // Shift amounts beyond 31 leave only the sign fill.
        if (a_q > 32'd31) begin
          a_n = {32{b_q[31]}};
        end else begin
          a_n = 32'($signed(b_q) >>> a_q[4:0]);
        end
      end
      OPC_ADJ: sp_n = sp_q + v;
      OPC_A2SP: begin
        sp_n = a_q;
        a_n  = b_q;
      end
      OPC_SP2A: begin
        b_n = a_q;
        a_n = sp_q;
      end
      OPC_CALL: begin
        b_n  = a_q;
        a_n  = pc_q;
        pc_n = pc_q + v;
      end
      OPC_RETURN: begin
        pc_n = a_q;
        a_n  = b_q;
      end
      OPC_BRZ: begin
        if (a_q == 32'd0) begin
          pc_n = pc_q + v;
        end
      end
      OPC_BRLZ: begin
        if (a_q[31]) begin
          pc_n = pc_q + v;
        end
      end
      OPC_BR: pc_n = pc_q + v;
      default: ;
    endcase
  end

  // Next state, store write and phase control.
  always_comb begin
    phase_d     = phase_q;
    clr_d       = clr_q;
    a_d         = a_q;
    b_d         = b_q;
    pc_d        = pc_q;
    sp_d        = sp_q;
    cnt_d       = cnt_q;
    stop_d      = stop_q;
    rword_d     = rword_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_wa      = addr_q;
    mem_wd      = wword_q;

    case (phase_q)
      PH_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + ADDR_BITS'(1);
        if (clr_q == {ADDR_BITS{1'b1}}) begin
          phase_d = PH_IDLE;
        end
      end
      PH_IDLE: begin
        if (accept) begin
          phase_d = PH_EXEC;
        end
      end
      PH_EXEC: begin
        if (commit) begin
          phase_d     = PH_IDLE;
          out_valid_d = 1'b1;
          rword_d     = '0;
          case (mode_q)
            MODE_WRITE: begin
              mem_we = 1'b1;
              mem_wd = wword_q;
            end
            MODE_EXEC: begin
              if (stop_q == STAT_RUN) begin
                if (opc > OPC_HALT) begin
                  stop_d = STAT_INVALID;
                end else if (opc == OPC_HALT) begin
                  cnt_d  = cnt_inc;
                  stop_d = STAT_HALT;
                end else begin
                  mem_we = st_we;
                  mem_wd = st_wd;
                  a_d    = a_n;
                  b_d    = b_n;
                  sp_d   = sp_n;
                  pc_d   = pc_n + 32'd1;
                  cnt_d  = cnt_inc;
                  if (cnt_inc > step_lim_q) begin
                    stop_d = STAT_STEP_LIM;
                  end else if ($signed(sp_n) > $signed(stack_lim_q)) begin
                    stop_d = STAT_STACK_OV;
                  end
                end
              end
            end
            MODE_READ: rword_d = rd_q;
            default: ;
          endcase
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CLEAR;
      clr_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      pc_q        <= '0;
      sp_q        <= '0;
      cnt_q       <= '0;
      stop_q      <= STAT_RUN;
      rword_q     <= '0;
      out_valid_q <= 1'b0;
      step_lim_q  <= STEP_LIMIT_RST;
      stack_lim_q <= STACK_LIMIT_RST;
    end else begin
      phase_q     <= phase_d;
      clr_q       <= clr_d;
      a_q         <= a_d;
      b_q         <= b_d;
      pc_q        <= pc_d;
      sp_q        <= sp_d;
      cnt_q       <= cnt_d;
      stop_q      <= stop_d;
      rword_q     <= rword_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_STEP_LIMIT:  step_lim_q  <= cfg_data_i;
          CFG_STACK_LIMIT: stack_lim_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Captured word; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      wword_q <= write_word_i;
      instr_q <= instruction_i;
      addr_q  <= in_addr;
    end
  end

  // Single-ported data store: read at accept, written at commit or by the
  // clearing pass. The two never fall in the same cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_q <= mem[in_addr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign acc_a_o        = a_q;
  assign acc_b_o        = b_q;
  assign prog_counter_o = pc_q;
  assign stack_ptr_o    = sp_q;
  assign status_o       = stop_q;
  assign read_word_o    = rword_q;
  assign steps_done_o   = cnt_q;

endmodule

`default_nettype wire
